// ===== src/ids_pkg.sv =====
// Shared constants, types and controller/datapath command structs for the dominator sets unit.
`default_nettype none

package ids_pkg;

    localparam int MAX_NODES = 32;
    localparam int NODE_W    = 6;
    localparam int OUT_MASK_W = 32;
    localparam int MASK_W    = MAX_NODES;
    localparam int IDX_W     = $clog2(MAX_NODES);
    localparam int CNT_W     = $clog2(MAX_NODES + 1);

    typedef logic [NODE_W-1:0] node_t;
    typedef logic [MASK_W-1:0] mask_t;
    typedef logic [CNT_W-1:0]  cnt_t;
    typedef logic [IDX_W-1:0]  idx_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_START,
        S_INIT,
        S_PASS,
        S_NODE,
        S_SWEEP,
        S_DRAIN,
        S_WRITE,
        S_EMIT_START,
        S_EMIT_RD,
        S_EMIT_LD,
        S_EMIT_WAIT,
        S_CLEAR
    } ids_state_t;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_INIT_BEGIN,
        OP_INIT_WRITE,
        OP_PASS_BEGIN,
        OP_NODE_BEGIN,
        OP_SWEEP,
        OP_DRAIN,
        OP_NODE_WRITE,
        OP_EMIT_BEGIN,
        OP_EMIT_READ,
        OP_EMIT_CAPTURE,
        OP_EMIT_NEXT,
        OP_CLEAR
    } ids_op_t;

    typedef struct packed {
        ids_op_t op;
    } ids_cmd_t;

    typedef struct packed {
        logic count_zero;
        logic count_one;
        logic k_last;
        logic p_last;
        logic pass_changed;
    } ids_status_t;

endpackage

`default_nettype wire

// ===== src/ids_if.sv =====
// Valid/ready channel interfaces for edge input and dominator result output.
`default_nettype none

interface ids_edge_if import ids_pkg::*; ();
    logic  valid;
    logic  ready;
    node_t edge_source;
    node_t edge_target;
    logic  last_edge;

    modport source (output valid, edge_source, edge_target, last_edge, input ready);
    modport sink   (input valid, edge_source, edge_target, last_edge, output ready);
endinterface

interface ids_result_if import ids_pkg::*; ();
    logic                  valid;
    logic                  ready;
    node_t                 node_number;
    logic [OUT_MASK_W-1:0] dominator_mask;
    logic                  last_node;

    modport source (output valid, node_number, dominator_mask, last_node, input ready);
    modport sink   (input valid, node_number, dominator_mask, last_node, output ready);
endinterface

`default_nettype wire

// ===== src/iterative_dominator_sets_unit.sv =====
// Top level of the iterative dominator sets unit: controller plus datapath.
//
//   channel   modport   payload                                   role
//   edges     sink      edge_source, edge_target, last_edge       graph edges in
//   results   source    node_number, dominator_mask, last_node    one set per node out
//
// Edges load one per cycle. After the last edge, with N the highest node number:
// a start state checks for an empty graph (which goes straight to the clear state),
// init writes the sets of nodes 1..N, each pass over nodes 2..N reads the sets
// through the single read port of the dominator set RAM, repeated until a pass changes
// nothing (no pass when N is 1); emission opens with a start state, each result is then
// read, captured and held until taken, and a clear state ends the run.
// Reset clears control state and the predecessor matrix at once; no clearing pass.
// A result is held in the output register while results.ready is low.
`default_nettype none

module iterative_dominator_sets_unit import ids_pkg::*; (
    input  wire logic   clk,
    input  wire logic   rst_n,
    ids_edge_if.sink    edges,
    ids_result_if.source results
);

    ids_cmd_t    cmd;
    ids_status_t status;

    ids_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (edges.valid),
        .in_last   (edges.last_edge),
        .in_ready  (edges.ready),
        .out_valid (results.valid),
        .out_ready (results.ready),
        .status    (status),
        .cmd       (cmd)
    );

    ids_datapath u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .status         (status),
        .edge_source    (edges.edge_source),
        .edge_target    (edges.edge_target),
        .node_number    (results.node_number),
        .dominator_mask (results.dominator_mask),
        .last_node      (results.last_node)
    );

    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(edges.ready && results.valid))
        else $error("edge input open while a result is pending");

    a_last_edge_stops: assert property (@(posedge clk) disable iff (!rst_n)
        (edges.valid && edges.ready && edges.last_edge) |=> !edges.ready)
        else $error("input still ready after the last edge");

    a_last_result_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (results.valid && results.ready && results.last_node) |=>
            (!results.valid && !edges.ready))
        else $error("emission did not stop after the last result");

    a_node_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        results.valid |-> (results.node_number != '0))
        else $error("result carries node number zero");

endmodule

`default_nettype wire

// ===== src/ids_ram.sv =====
// Generic single write port, single read port RAM with registered read data.
`default_nettype none

module ids_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// ===== src/ids_ctrl.sv =====
// Controller state machine: edge loading, fixed-point sequencing and result emission.
`default_nettype none

module ids_ctrl import ids_pkg::*; (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    input  wire logic        in_last,
    output logic             in_ready,
    output logic             out_valid,
    input  wire logic        out_ready,
    input  wire ids_status_t status,
    output ids_cmd_t         cmd
);

    ids_state_t state_reg;
    ids_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd.op     = OP_NONE;
        in_ready   = 1'b0;
        out_valid  = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.op = OP_LOAD;
                    if (in_last)
                    begin
                        state_next = S_START;
                    end
                end
            end
            S_START:
            begin
                if (status.count_zero)
                begin
                    state_next = S_CLEAR;
                end
                else
                begin
                    cmd.op     = OP_INIT_BEGIN;
                    state_next = S_INIT;
                end
            end
            S_INIT:
            begin
                cmd.op = OP_INIT_WRITE;
                if (status.k_last)
                begin
                    state_next = status.count_one ? S_EMIT_START : S_PASS;
                end
            end
            S_PASS:
            begin
                cmd.op     = OP_PASS_BEGIN;
                state_next = S_NODE;
            end
            S_NODE:
            begin
                cmd.op     = OP_NODE_BEGIN;
                state_next = S_SWEEP;
            end
            S_SWEEP:
            begin
                cmd.op = OP_SWEEP;
                if (status.p_last)
                begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN:
            begin
                cmd.op     = OP_DRAIN;
                state_next = S_WRITE;
            end
            S_WRITE:
            begin
                cmd.op = OP_NODE_WRITE;
                if (!status.k_last)
                begin
                    state_next = S_NODE;
                end
                else if (status.pass_changed)
                begin
                    state_next = S_PASS;
                end
                else
                begin
                    state_next = S_EMIT_START;
                end
            end
            S_EMIT_START:
            begin
                cmd.op     = OP_EMIT_BEGIN;
                state_next = S_EMIT_RD;
            end
            S_EMIT_RD:
            begin
                cmd.op     = OP_EMIT_READ;
                state_next = S_EMIT_LD;
            end
            S_EMIT_LD:
            begin
                cmd.op     = OP_EMIT_CAPTURE;
                state_next = S_EMIT_WAIT;
            end
            S_EMIT_WAIT:
            begin
                out_valid = 1'b1;
                if (out_ready)
                begin
                    if (status.k_last)
                    begin
                        state_next = S_CLEAR;
                    end
                    else
                    begin
                        cmd.op     = OP_EMIT_NEXT;
                        state_next = S_EMIT_RD;
                    end
                end
            end
            S_CLEAR:
            begin
                cmd.op     = OP_CLEAR;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== src/ids_datapath.sv =====
// Datapath: predecessor matrix, dominator set RAM, meet logic and result register.
`default_nettype none

module ids_datapath import ids_pkg::*; (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire ids_cmd_t              cmd,
    output ids_status_t                status,
    input  wire node_t                 edge_source,
    input  wire node_t                 edge_target,
    output node_t                      node_number,
    output logic [OUT_MASK_W-1:0]      dominator_mask,
    output logic                       last_node
);

    logic [MAX_NODES-1:0][MASK_W-1:0] pred_reg;
    cnt_t                             highest_reg;
    cnt_t                             k_reg;
    cnt_t                             p_reg;
    cnt_t                             pq_reg;
    logic                             pq_valid_reg;
    logic                             changed_reg;
    mask_t                            meet_reg;
    mask_t                            old_reg;
    node_t                            node_reg;
    logic [OUT_MASK_W-1:0]            mask_reg;
    logic                             last_reg;

    logic                  edge_ok;
    cnt_t                  src_c;
    cnt_t                  dst_c;
    cnt_t                  highest_next;
    mask_t                 all_mask;
    mask_t                 preds;
    mask_t                 k_bit;
    mask_t                 final_set;
    logic                  differs;
    idx_t                  k_idx;
    idx_t                  pq_idx;
    logic                  ram_we;
    idx_t                  ram_waddr;
    mask_t                 ram_wdata;
    idx_t                  ram_raddr;
    mask_t                 ram_rdata;
    logic [OUT_MASK_W-1:0] mask_out;

    assign edge_ok = (edge_source != '0) && (int'(edge_source) <= MAX_NODES) &&
                     (edge_target != '0) && (int'(edge_target) <= MAX_NODES);
    assign src_c   = CNT_W'(edge_source);
    assign dst_c   = CNT_W'(edge_target);

    always_comb
    begin
        highest_next = highest_reg;
        if (src_c > highest_next)
        begin
            highest_next = src_c;
        end
        if (dst_c > highest_next)
        begin
            highest_next = dst_c;
        end
    end

    always_comb
    begin
        for (int b = 0; b < MASK_W; b++)
        begin
            all_mask[b] = (b < int'(highest_reg));
        end
    end

    assign k_idx     = IDX_W'(k_reg - cnt_t'(1));
    assign pq_idx    = IDX_W'(pq_reg - cnt_t'(1));
    assign preds     = pred_reg[k_idx] & all_mask;
    assign k_bit     = mask_t'(1) << k_idx;
    // a non-root node with no predecessors is dominated only by the root and itself
    assign final_set = ((preds == '0) ? mask_t'(1) : meet_reg) | k_bit;
    assign differs   = (final_set != old_reg);

    always_comb
    begin
        ram_we    = 1'b0;
        ram_waddr = k_idx;
        ram_wdata = final_set;
        case (cmd.op)
            OP_INIT_WRITE:
            begin
                ram_we    = 1'b1;
                ram_wdata = (k_reg == cnt_t'(1)) ? mask_t'(1) : all_mask;
            end
            OP_NODE_WRITE:
            begin
                ram_we = differs;
            end
            default:
            begin
                ram_we = 1'b0;
            end
        endcase
    end

    assign ram_raddr = (cmd.op == OP_EMIT_READ) ? k_idx : IDX_W'(p_reg - cnt_t'(1));

    ids_ram #(
        .WIDTH (MASK_W),
        .DEPTH (MAX_NODES)
    ) u_dom_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        for (int b = 0; b < OUT_MASK_W; b++)
        begin
            mask_out[b] = (b < MASK_W) && ram_rdata[IDX_W'(b)];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pred_reg     <= '0;
            highest_reg  <= '0;
            k_reg        <= '0;
            p_reg        <= '0;
            pq_reg       <= '0;
            pq_valid_reg <= 1'b0;
            changed_reg  <= 1'b0;
        end
        else
        begin
            case (cmd.op)
                OP_LOAD:
                begin
                    if (edge_ok)
                    begin
                        pred_reg[IDX_W'(edge_target - node_t'(1))]
                                [IDX_W'(edge_source - node_t'(1))] <= 1'b1;
                        highest_reg <= highest_next;
                    end
                end
                OP_INIT_BEGIN, OP_EMIT_BEGIN:
                begin
                    k_reg <= cnt_t'(1);
                end
                OP_INIT_WRITE, OP_EMIT_NEXT:
                begin
                    k_reg <= k_reg + cnt_t'(1);
                end
                OP_PASS_BEGIN:
                begin
                    changed_reg <= 1'b0;
                    k_reg       <= cnt_t'(2);
                end
                OP_NODE_BEGIN:
                begin
                    p_reg <= cnt_t'(1);
                end
                OP_SWEEP:
                begin
                    pq_reg       <= p_reg;
                    pq_valid_reg <= 1'b1;
                    p_reg        <= p_reg + cnt_t'(1);
                end
                OP_DRAIN:
                begin
                    pq_valid_reg <= 1'b0;
                end
                OP_NODE_WRITE:
                begin
                    if (differs)
                    begin
                        changed_reg <= 1'b1;
                    end
                    k_reg <= k_reg + cnt_t'(1);
                end
                OP_CLEAR:
                begin
                    pred_reg    <= '0;
                    highest_reg <= '0;
                end
                default:
                begin
                    k_reg <= k_reg;
                end
            endcase
        end
    end

    // fold in the registered RAM read of predecessor pq; grab the node's own old set on the way
    always_ff @(posedge clk)
    begin
        if (cmd.op == OP_NODE_BEGIN)
        begin
            meet_reg <= all_mask;
        end
        else if (pq_valid_reg && preds[pq_idx])
        begin
            meet_reg <= meet_reg & ram_rdata;
        end
        if (pq_valid_reg && (pq_reg == k_reg))
        begin
            old_reg <= ram_rdata;
        end
        if (cmd.op == OP_EMIT_CAPTURE)
        begin
            node_reg <= NODE_W'(k_reg);
            mask_reg <= mask_out;
            last_reg <= (k_reg == highest_reg);
        end
    end

    assign status.count_zero   = (highest_reg == '0);
    assign status.count_one    = (highest_reg == cnt_t'(1));
    assign status.k_last       = (k_reg == highest_reg);
    assign status.p_last       = (p_reg == highest_reg);
    assign status.pass_changed = changed_reg | differs;

    assign node_number    = node_reg;
    assign dominator_mask = mask_reg;
    assign last_node      = last_reg;

endmodule

`default_nettype wire
